// File: sv/pts_pkg.sv
// pts_pkg: shared types and constants for the priority time-slice scheduler
// no dependencies; imported by pts_table, pts_ctrl and the top level
`timescale 1ns / 1ps

package pts_pkg;

    localparam int PID_W   = 16;
    localparam int PRIO_W  = 8;
    localparam int SLICE_W = 16;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;
    localparam logic [PID_W-1:0]   PID_FIRST   = 16'd1;
    localparam logic [PID_W-1:0]   PID_LAST    = 16'hFFFF;

    // command codes
    localparam logic [2:0] CMD_CREATE    = 3'd0;
    localparam logic [2:0] CMD_KILL      = 3'd1;
    localparam logic [2:0] CMD_YIELD     = 3'd2;
    localparam logic [2:0] CMD_TICK      = 3'd3;
    localparam logic [2:0] CMD_KILL_SELF = 3'd4;

    typedef enum logic [1:0] {
        ST_FREE  = 2'd0,
        ST_READY = 2'd1,
        ST_RUN   = 2'd2
    } slot_state_t;

    typedef enum logic [1:0] {
        RES_OK        = 2'd0,
        RES_NO_SLOT   = 2'd1,
        RES_KERNEL    = 2'd2,
        RES_NOT_FOUND = 2'd3
    } result_t;

    // per-field write enables of the task table
    typedef struct packed {
        logic status;
        logic pid;
        logic prio;
        logic nxt;
        logic prv;
    } wmask_t;

endpackage

// File: sv/pts_table.sv
// pts_table: task table memory, one write and one registered read per cycle
// depends on pts_pkg; unwritten fields read as their reset values
`timescale 1ns / 1ps

module pts_table
    import pts_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
    input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
    input  wmask_t                       wr_mask,
    input  slot_state_t                  wr_status,
    input  logic [PID_W-1:0]             wr_pid,
    input  logic [PRIO_W-1:0]            wr_prio,
    input  logic [$clog2(NUM_SLOTS):0]   wr_next,
    input  logic [$clog2(NUM_SLOTS):0]   wr_prev,
    output slot_state_t                  rd_status,
    output logic [PID_W-1:0]             rd_pid,
    output logic [PRIO_W-1:0]            rd_prio,
    output logic [$clog2(NUM_SLOTS):0]   rd_next,
    output logic [$clog2(NUM_SLOTS):0]   rd_prev
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int LW = SW + 1;
    localparam logic [LW-1:0] NIL = LW'(NUM_SLOTS);

    slot_state_t       status_mem [NUM_SLOTS];
    logic [PID_W-1:0]  pid_mem    [NUM_SLOTS];
    logic [PRIO_W-1:0] prio_mem   [NUM_SLOTS];
    logic [LW-1:0]     next_mem   [NUM_SLOTS];
    logic [LW-1:0]     prev_mem   [NUM_SLOTS];

    logic [NUM_SLOTS-1:0] v_status_reg;
    logic [NUM_SLOTS-1:0] v_pid_reg;
    logic [NUM_SLOTS-1:0] v_prio_reg;
    logic [NUM_SLOTS-1:0] v_next_reg;
    logic [NUM_SLOTS-1:0] v_prev_reg;

    always_ff @(posedge clk)
    begin
        if (wr_mask.status) status_mem[wr_addr] <= wr_status;
        if (wr_mask.pid)    pid_mem[wr_addr]    <= wr_pid;
        if (wr_mask.prio)   prio_mem[wr_addr]   <= wr_prio;
        if (wr_mask.nxt)    next_mem[wr_addr]   <= wr_next;
        if (wr_mask.prv)    prev_mem[wr_addr]   <= wr_prev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_status_reg <= '0;
            v_pid_reg    <= '0;
            v_prio_reg   <= '0;
            v_next_reg   <= '0;
            v_prev_reg   <= '0;
        end
        else
        begin
            if (wr_mask.status) v_status_reg[wr_addr] <= 1'b1;
            if (wr_mask.pid)    v_pid_reg[wr_addr]    <= 1'b1;
            if (wr_mask.prio)   v_prio_reg[wr_addr]   <= 1'b1;
            if (wr_mask.nxt)    v_next_reg[wr_addr]   <= 1'b1;
            if (wr_mask.prv)    v_prev_reg[wr_addr]   <= 1'b1;
        end
    end

    // registered read; slot zero starts out running
    always_ff @(posedge clk)
    begin
        if (v_status_reg[rd_addr])
            rd_status <= status_mem[rd_addr];
        else
            rd_status <= (rd_addr == '0) ? ST_RUN : ST_FREE;
        rd_pid  <= v_pid_reg[rd_addr]  ? pid_mem[rd_addr]  : '0;
        rd_prio <= v_prio_reg[rd_addr] ? prio_mem[rd_addr] : '0;
        rd_next <= v_next_reg[rd_addr] ? next_mem[rd_addr] : NIL;
        rd_prev <= v_prev_reg[rd_addr] ? prev_mem[rd_addr] : NIL;
    end

endmodule

// File: sv/pts_ctrl.sv
// pts_ctrl: command sequencer, walks the task table and the ready queue
// depends on pts_pkg; drives the pts_table ports
`timescale 1ns / 1ps

module pts_ctrl
    import pts_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sched_enable,
    input  logic [SLICE_W-1:0]           slice_length,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   cmd,
    input  logic [PRIO_W-1:0]            task_priority,
    input  logic [PID_W-1:0]             target_pid,
    output logic                         done,
    output logic [1:0]                   status,
    output logic [PID_W-1:0]             new_pid,
    output logic [PID_W-1:0]             running_pid,
    output logic [3:0]                   running_slot,
    output logic                         switched,
    output logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
    output logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
    output wmask_t                       wr_mask,
    output slot_state_t                  wr_status,
    output logic [PID_W-1:0]             wr_pid,
    output logic [PRIO_W-1:0]            wr_prio,
    output logic [$clog2(NUM_SLOTS):0]   wr_next,
    output logic [$clog2(NUM_SLOTS):0]   wr_prev,
    input  slot_state_t                  rd_status,
    input  logic [PID_W-1:0]             rd_pid,
    input  logic [PRIO_W-1:0]            rd_prio,
    input  logic [$clog2(NUM_SLOTS):0]   rd_next,
    input  logic [$clog2(NUM_SLOTS):0]   rd_prev
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int LW = SW + 1;
    localparam logic [LW-1:0] NIL = LW'(NUM_SLOTS);

    typedef enum logic [25:0] {
        S_IDLE       = 26'd1,
        S_SCAN       = 26'd2,
        S_CR_WR      = 26'd4,
        S_ENQ_START  = 26'd8,
        S_ENQ_TEST   = 26'd16,
        S_ENQ_CHK    = 26'd32,
        S_ENQ_WS     = 26'd64,
        S_ENQ_WP     = 26'd128,
        S_ENQ_WC     = 26'd256,
        S_UNL_RD     = 26'd512,
        S_UNL_GET    = 26'd1024,
        S_UNL_WN     = 26'd2048,
        S_UNL_WS     = 26'd4096,
        S_C4_RD      = 26'd8192,
        S_C4_CHK     = 26'd16384,
        S_FREE_START = 26'd32768,
        S_FREE_WR    = 26'd65536,
        S_RS_START   = 26'd131072,
        S_RS_CURCHK  = 26'd262144,
        S_RS_CMP     = 26'd524288,
        S_RS_OLD     = 26'd1048576,
        S_RS_NXT_RD  = 26'd2097152,
        S_RS_NXT     = 26'd4194304,
        S_RS_RUN     = 26'd8388608,
        S_FIN        = 26'd16777216,
        S_DONE       = 26'd33554432
    } state_t;

    state_t             state_reg,     state_next;
    state_t             ret_enq_reg,   ret_enq_next;
    state_t             ret_unl_reg,   ret_unl_next;
    logic               scan_cr_reg,   scan_cr_next;
    logic [PRIO_W-1:0]  prio_reg,      prio_next;
    logic [PID_W-1:0]   target_reg,    target_next;
    logic [LW-1:0]      idx_reg,       idx_next;
    logic               pend_reg,      pend_next;
    logic [SW-1:0]      enq_s_reg,     enq_s_next;
    logic [PRIO_W-1:0]  enq_prio_reg,  enq_prio_next;
    logic [LW-1:0]      cur_reg,       cur_next;
    logic [LW-1:0]      prv_reg,       prv_next;
    logic [SW-1:0]      unl_s_reg,     unl_s_next;
    logic [LW-1:0]      unl_p_reg,     unl_p_next;
    logic [LW-1:0]      unl_n_reg,     unl_n_next;
    logic [SW-1:0]      fs_reg,        fs_next;
    slot_state_t        fs_status_reg, fs_status_next;
    logic [SW-1:0]      nxt_reg,       nxt_next;
    logic [SW-1:0]      old_reg,       old_next;
    logic [LW-1:0]      head_reg,      head_next;
    logic [SW-1:0]      current_reg,   current_next;
    logic [SLICE_W-1:0] slice_reg,     slice_next;
    logic [PID_W-1:0]   pidc_reg,      pidc_next;
    logic [SW-1:0]      before_reg,    before_next;
    result_t            result_reg,    result_next;
    logic [PID_W-1:0]   new_pid_reg,   new_pid_next;

    logic               scan_hit;
    logic [SLICE_W-1:0] slice_dec;
    logic [SW+3:0]      slot_ext;

    assign scan_hit = pend_reg && (scan_cr_reg ? (rd_status == ST_FREE)
                      : (rd_status != ST_FREE && rd_pid == target_reg));
    assign slice_dec = (slice_reg != '0) ? slice_reg - 1'b1 : '0;

    always_comb
    begin
        state_next     = state_reg;
        ret_enq_next   = ret_enq_reg;
        ret_unl_next   = ret_unl_reg;
        scan_cr_next   = scan_cr_reg;
        prio_next      = prio_reg;
        target_next    = target_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        enq_s_next     = enq_s_reg;
        enq_prio_next  = enq_prio_reg;
        cur_next       = cur_reg;
        prv_next       = prv_reg;
        unl_s_next     = unl_s_reg;
        unl_p_next     = unl_p_reg;
        unl_n_next     = unl_n_reg;
        fs_next        = fs_reg;
        fs_status_next = fs_status_reg;
        nxt_next       = nxt_reg;
        old_next       = old_reg;
        head_next      = head_reg;
        current_next   = current_reg;
        slice_next     = slice_reg;
        pidc_next      = pidc_reg;
        before_next    = before_reg;
        result_next    = result_reg;
        new_pid_next   = new_pid_reg;
        rd_addr        = '0;
        wr_addr        = '0;
        wr_mask        = '0;
        wr_status      = ST_FREE;
        wr_pid         = '0;
        wr_prio        = '0;
        wr_next        = NIL;
        wr_prev        = NIL;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    before_next  = current_reg;
                    result_next  = RES_OK;
                    new_pid_next = '0;
                    case (cmd)
                        CMD_CREATE:
                        begin
                            scan_cr_next = 1'b1;
                            prio_next    = task_priority;
                            idx_next     = LW'(1);
                            pend_next    = 1'b0;
                            state_next   = S_SCAN;
                        end
                        CMD_KILL:
                        begin
                            if (target_pid == '0)
                            begin
                                result_next = RES_KERNEL;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                scan_cr_next = 1'b0;
                                target_next  = target_pid;
                                idx_next     = '0;
                                pend_next    = 1'b0;
                                state_next   = S_SCAN;
                            end
                        end
                        CMD_YIELD:
                        begin
                            if (sched_enable)
                            begin
                                slice_next = slice_length;
                                state_next = S_RS_START;
                            end
                            else
                                state_next = S_FIN;
                        end
                        CMD_TICK:
                        begin
                            if (sched_enable)
                            begin
                                slice_next = slice_dec;
                                state_next = (slice_dec == '0) ? S_RS_START : S_FIN;
                            end
                            else
                                state_next = S_FIN;
                        end
                        CMD_KILL_SELF:
                        begin
                            if (current_reg == '0)
                            begin
                                result_next = RES_KERNEL;
                                state_next  = S_FIN;
                            end
                            else
                                state_next = S_C4_RD;
                        end
                        default: state_next = S_FIN;
                    endcase
                end
            end
            S_SCAN:
            begin
                rd_addr = idx_reg[SW-1:0];
                if (scan_hit)
                begin
                    fs_next        = SW'(idx_reg - 1'b1);
                    fs_status_next = rd_status;
                    state_next     = scan_cr_reg ? S_CR_WR : S_FREE_START;
                end
                else if (idx_reg == NIL)
                begin
                    result_next = scan_cr_reg ? RES_NO_SLOT : RES_NOT_FOUND;
                    state_next  = S_FIN;
                end
                else
                begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end
            S_CR_WR:
            begin
                wr_addr        = fs_reg;
                wr_mask.status = 1'b1;
                wr_mask.pid    = 1'b1;
                wr_mask.prio   = 1'b1;
                wr_status      = ST_READY;
                wr_pid         = pidc_reg;
                wr_prio        = prio_reg;
                new_pid_next   = pidc_reg;
                pidc_next      = (pidc_reg == PID_LAST) ? PID_FIRST : pidc_reg + 1'b1;
                enq_s_next     = fs_reg;
                enq_prio_next  = prio_reg;
                ret_enq_next   = S_FIN;
                state_next     = S_ENQ_START;
            end
            S_ENQ_START:
            begin
                cur_next   = head_reg;
                prv_next   = NIL;
                state_next = S_ENQ_TEST;
            end
            S_ENQ_TEST:
            begin
                if (cur_reg == NIL)
                    state_next = S_ENQ_WS;
                else
                begin
                    rd_addr    = cur_reg[SW-1:0];
                    state_next = S_ENQ_CHK;
                end
            end
            S_ENQ_CHK:
            begin
                // walk past every entry of equal or better priority
                if (rd_prio <= enq_prio_reg)
                begin
                    prv_next   = cur_reg;
                    cur_next   = rd_next;
                    state_next = S_ENQ_TEST;
                end
                else
                    state_next = S_ENQ_WS;
            end
            S_ENQ_WS:
            begin
                wr_addr     = enq_s_reg;
                wr_mask.nxt = 1'b1;
                wr_mask.prv = 1'b1;
                wr_next     = cur_reg;
                wr_prev     = prv_reg;
                state_next  = S_ENQ_WP;
            end
            S_ENQ_WP:
            begin
                if (prv_reg != NIL)
                begin
                    wr_addr     = prv_reg[SW-1:0];
                    wr_mask.nxt = 1'b1;
                    wr_next     = LW'(enq_s_reg);
                end
                else
                    head_next = LW'(enq_s_reg);
                state_next = S_ENQ_WC;
            end
            S_ENQ_WC:
            begin
                if (cur_reg != NIL)
                begin
                    wr_addr     = cur_reg[SW-1:0];
                    wr_mask.prv = 1'b1;
                    wr_prev     = LW'(enq_s_reg);
                end
                state_next = ret_enq_reg;
            end
            S_UNL_RD:
            begin
                rd_addr    = unl_s_reg;
                state_next = S_UNL_GET;
            end
            S_UNL_GET:
            begin
                unl_p_next = rd_prev;
                unl_n_next = rd_next;
                if (rd_prev != NIL)
                begin
                    wr_addr     = rd_prev[SW-1:0];
                    wr_mask.nxt = 1'b1;
                    wr_next     = rd_next;
                end
                else
                    head_next = rd_next;
                state_next = S_UNL_WN;
            end
            S_UNL_WN:
            begin
                if (unl_n_reg != NIL)
                begin
                    wr_addr     = unl_n_reg[SW-1:0];
                    wr_mask.prv = 1'b1;
                    wr_prev     = unl_p_reg;
                end
                state_next = S_UNL_WS;
            end
            S_UNL_WS:
            begin
                wr_addr     = unl_s_reg;
                wr_mask.nxt = 1'b1;
                wr_mask.prv = 1'b1;
                state_next  = ret_unl_reg;
            end
            S_C4_RD:
            begin
                rd_addr    = current_reg;
                state_next = S_C4_CHK;
            end
            S_C4_CHK:
            begin
                if (rd_status == ST_FREE)
                begin
                    result_next = RES_NOT_FOUND;
                    state_next  = S_FIN;
                end
                else
                begin
                    fs_next        = current_reg;
                    fs_status_next = rd_status;
                    state_next     = S_FREE_START;
                end
            end
            S_FREE_START:
            begin
                if (fs_status_reg == ST_READY)
                begin
                    unl_s_next   = fs_reg;
                    ret_unl_next = S_FREE_WR;
                    state_next   = S_UNL_RD;
                end
                else
                    state_next = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                wr_addr        = fs_reg;
                wr_mask.status = 1'b1;
                wr_mask.pid    = 1'b1;
                wr_mask.prio   = 1'b1;
                state_next     = (fs_reg == current_reg) ? S_RS_START : S_FIN;
            end
            S_RS_START:
            begin
                if (!sched_enable)
                    state_next = S_FIN;
                else if (head_reg == NIL)
                begin
                    rd_addr    = current_reg;
                    state_next = S_RS_CURCHK;
                end
                else
                begin
                    nxt_next   = head_reg[SW-1:0];
                    state_next = S_RS_CMP;
                end
            end
            S_RS_CURCHK:
            begin
                if (rd_status == ST_RUN)
                    state_next = S_FIN;
                else
                begin
                    nxt_next   = '0;
                    state_next = S_RS_CMP;
                end
            end
            S_RS_CMP:
            begin
                if (nxt_reg == current_reg)
                    state_next = S_FIN;
                else
                begin
                    old_next   = current_reg;
                    rd_addr    = current_reg;
                    state_next = S_RS_OLD;
                end
            end
            S_RS_OLD:
            begin
                // a preempted kernel task is not queued
                if (rd_status == ST_RUN && old_reg != '0)
                begin
                    wr_addr        = old_reg;
                    wr_mask.status = 1'b1;
                    wr_status      = ST_READY;
                    enq_s_next     = old_reg;
                    enq_prio_next  = rd_prio;
                    ret_enq_next   = S_RS_NXT_RD;
                    state_next     = S_ENQ_START;
                end
                else
                    state_next = S_RS_NXT_RD;
            end
            S_RS_NXT_RD:
            begin
                rd_addr    = nxt_reg;
                state_next = S_RS_NXT;
            end
            S_RS_NXT:
            begin
                if (rd_status == ST_READY)
                begin
                    unl_s_next   = nxt_reg;
                    ret_unl_next = S_RS_RUN;
                    state_next   = S_UNL_RD;
                end
                else
                    state_next = S_RS_RUN;
            end
            S_RS_RUN:
            begin
                wr_addr        = nxt_reg;
                wr_mask.status = 1'b1;
                wr_status      = ST_RUN;
                slice_next     = slice_length;
                current_next   = nxt_reg;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                rd_addr    = current_reg;
                state_next = S_DONE;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_enq_reg   <= S_FIN;
            ret_unl_reg   <= S_FIN;
            scan_cr_reg   <= 1'b0;
            prio_reg      <= '0;
            target_reg    <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            enq_s_reg     <= '0;
            enq_prio_reg  <= '0;
            cur_reg       <= NIL;
            prv_reg       <= NIL;
            unl_s_reg     <= '0;
            unl_p_reg     <= NIL;
            unl_n_reg     <= NIL;
            fs_reg        <= '0;
            fs_status_reg <= ST_FREE;
            nxt_reg       <= '0;
            old_reg       <= '0;
            head_reg      <= NIL;
            current_reg   <= '0;
            slice_reg     <= SLICE_RESET;
            pidc_reg      <= PID_FIRST;
            before_reg    <= '0;
            result_reg    <= RES_OK;
            new_pid_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_enq_reg   <= ret_enq_next;
            ret_unl_reg   <= ret_unl_next;
            scan_cr_reg   <= scan_cr_next;
            prio_reg      <= prio_next;
            target_reg    <= target_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            enq_s_reg     <= enq_s_next;
            enq_prio_reg  <= enq_prio_next;
            cur_reg       <= cur_next;
            prv_reg       <= prv_next;
            unl_s_reg     <= unl_s_next;
            unl_p_reg     <= unl_p_next;
            unl_n_reg     <= unl_n_next;
            fs_reg        <= fs_next;
            fs_status_reg <= fs_status_next;
            nxt_reg       <= nxt_next;
            old_reg       <= old_next;
            head_reg      <= head_next;
            current_reg   <= current_next;
            slice_reg     <= slice_next;
            pidc_reg      <= pidc_next;
            before_reg    <= before_next;
            result_reg    <= result_next;
            new_pid_reg   <= new_pid_next;
        end
    end

    assign slot_ext     = {4'b0000, current_reg};
    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_DONE);
    assign status       = result_reg;
    assign new_pid      = new_pid_reg;
    assign running_pid  = rd_pid;
    assign running_slot = slot_ext[3:0];
    assign switched     = (current_reg != before_reg);

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("sequencer did not return to idle after a result");

    a_accept_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("result strobed in the cycle after a command was taken");

    a_pid_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && new_pid != '0) |-> (status == RES_OK))
        else $error("new pid reported with a failure status");

    a_pid_never_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pidc_reg != '0)
        else $error("pid counter reached zero");

endmodule

// File: sv/priority_time_slice_scheduler.sv
// priority_time_slice_scheduler: top level, apb registers, sequencer and task table
// depends on pts_pkg, pts_table and pts_ctrl
//
// channel   | signals                                         | transaction
// ----------+-------------------------------------------------+----------------------------
// command   | start, busy, cmd, task_priority, target_pid     | start high while busy low
// result    | done, status, new_pid, running_pid, running_slot,| done high for one cycle
//           | switched                                        |
// config    | psel, penable, pwrite, paddr, pwdata, prdata,   | apb access phase, pready=1
//           | pready                                          |
//
// one command at a time; busy stays high from the cycle after start until done
// done comes straight through S_FIN and S_DONE for a tick that leaves slice time, an
// unknown command, a kernel refusal or yield/tick while disabled; a reschedule can keep
// the running task; a create scans one slot per cycle from slot 1 then walks the queue,
// reading and comparing each entry; a switch requeues and unlinks; a terminate scans up
// to NUM_SLOTS slots; the sequencer makes at most one table read and one table write
// per cycle
// async active-low reset: slot 0 runs, queue empty, pid counter one, slice ten
// results cannot be stalled; done is a one-cycle strobe
`timescale 1ns / 1ps

module priority_time_slice_scheduler
    import pts_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // command transaction
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         cmd,
    input  logic [PRIO_W-1:0]  task_priority,
    input  logic [PID_W-1:0]   target_pid,
    // result transaction
    output logic               done,
    output logic [1:0]         status,
    output logic [PID_W-1:0]   new_pid,
    output logic [PID_W-1:0]   running_pid,
    output logic [3:0]         running_slot,
    output logic               switched
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int LW = SW + 1;

    // register map: byte 0 enable, byte 4 slice length; low address bits ignored
    logic               sched_enable_reg;
    logic [SLICE_W-1:0] slice_length_reg;
    logic               cfg_wr;

    // table port between sequencer and memory
    logic [SW-1:0]      rd_addr;
    logic [SW-1:0]      wr_addr;
    wmask_t             wr_mask;
    slot_state_t        wr_status;
    logic [PID_W-1:0]   wr_pid;
    logic [PRIO_W-1:0]  wr_prio;
    logic [LW-1:0]      wr_next;
    logic [LW-1:0]      wr_prev;
    slot_state_t        rd_status;
    logic [PID_W-1:0]   rd_pid;
    logic [PRIO_W-1:0]  rd_prio;
    logic [LW-1:0]      rd_next;
    logic [LW-1:0]      rd_prev;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_enable_reg <= 1'b0;
            slice_length_reg <= SLICE_RESET;
        end
        else if (cfg_wr)
        begin
            // register select by word address
            if (paddr[2])
                slice_length_reg <= pwdata[SLICE_W-1:0];
            else
                sched_enable_reg <= pwdata[0];
        end
    end

    assign prdata = paddr[2] ? {16'h0000, slice_length_reg} : {31'h0, sched_enable_reg};

    // sequencer: one table access per cycle, reads are registered and return in the next cycle
    pts_ctrl #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .sched_enable  (sched_enable_reg),
        .slice_length  (slice_length_reg),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .task_priority (task_priority),
        .target_pid    (target_pid),
        .done          (done),
        .status        (status),
        .new_pid       (new_pid),
        .running_pid   (running_pid),
        .running_slot  (running_slot),
        .switched      (switched),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .wr_mask       (wr_mask),
        .wr_status     (wr_status),
        .wr_pid        (wr_pid),
        .wr_prio       (wr_prio),
        .wr_next       (wr_next),
        .wr_prev       (wr_prev),
        .rd_status     (rd_status),
        .rd_pid        (rd_pid),
        .rd_prio       (rd_prio),
        .rd_next       (rd_next),
        .rd_prev       (rd_prev)
    );

    // task table: status, pid, priority and queue links per slot
    pts_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .wr_mask   (wr_mask),
        .wr_status (wr_status),
        .wr_pid    (wr_pid),
        .wr_prio   (wr_prio),
        .wr_next   (wr_next),
        .wr_prev   (wr_prev),
        .rd_status (rd_status),
        .rd_pid    (rd_pid),
        .rd_prio   (rd_prio),
        .rd_next   (rd_next),
        .rd_prev   (rd_prev)
    );

endmodule

// File: sim/testbench.sv
// testbench: self-checking bench for the priority time-slice scheduler
// depends on pts_pkg and priority_time_slice_scheduler; drives commands and apb writes,
// predicts every result with an internal scheduler model and compares field by field
`timescale 1ns / 1ps

module testbench;
    import pts_pkg::*;

    localparam int NSLOT = 16;
    localparam int NIL = NSLOT;

    // register byte addresses
    localparam logic [2:0] ADDR_ENABLE = 3'd0;
    localparam logic [2:0] ADDR_SLICE  = 3'd4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  cmd = '0;
    logic [PRIO_W-1:0] task_priority = '0;
    logic [PID_W-1:0]  target_pid = '0;
    logic        done;
    logic [1:0]  status;
    logic [PID_W-1:0] new_pid;
    logic [PID_W-1:0] running_pid;
    logic [3:0]  running_slot;
    logic        switched;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] new_pid;
        logic [15:0] running_pid;
        logic [3:0]  running_slot;
        logic        switched;
    } sched_result_t;

    sched_result_t pending_results[$];
    int error_count = 0;
    bit idle_enable = 1'b1;

    // scheduler model state
    bit          m_enable;
    logic [15:0] m_slice_len;
    slot_state_t m_state [NSLOT];
    logic [15:0] m_pid [NSLOT];
    logic [7:0]  m_prio [NSLOT];
    int          m_next [NSLOT];
    int          m_prev [NSLOT];
    int          m_head;
    int          m_cur;
    logic [15:0] m_slice_left;
    logic [15:0] m_pid_ctr;

    priority_time_slice_scheduler #(.NUM_SLOTS(NSLOT)) dut (.*);

    always #2 clk = ~clk;

    // ---------------- model ----------------
    task automatic model_reset();
        m_enable = 0;
        m_slice_len = SLICE_RESET;
        for (int i = 0; i < NSLOT; i++)
        begin
            m_state[i] = ST_FREE;
            m_pid[i] = '0;
            m_prio[i] = '0;
            m_next[i] = NIL;
            m_prev[i] = NIL;
        end
        m_state[0] = ST_RUN;
        m_head = NIL;
        m_cur = 0;
        m_slice_left = m_slice_len;
        m_pid_ctr = PID_FIRST;
    endtask

    task automatic queue_remove(int s);
        int p;
        int n;
        p = m_prev[s];
        n = m_next[s];
        if (p < NSLOT) m_next[p] = n; else m_head = n;
        if (n < NSLOT) m_prev[n] = p;
        m_next[s] = NIL;
        m_prev[s] = NIL;
    endtask

    // insert behind every entry with priority value <= own
    task automatic queue_insert(int s);
        int c;
        int p;
        int guard;
        c = m_head;
        p = NIL;
        guard = 0;
        while (c < NSLOT && guard < NSLOT && m_prio[c] <= m_prio[s])
        begin
            p = c;
            c = m_next[c];
            guard++;
        end
        m_next[s] = c;
        m_prev[s] = p;
        if (p < NSLOT) m_next[p] = s; else m_head = s;
        if (c < NSLOT) m_prev[c] = s;
    endtask

    task automatic pick_next_task();
        int nxt;
        int old;
        if (!m_enable) return;
        nxt = m_head;
        if (nxt >= NSLOT)
        begin
            if (m_state[m_cur] == ST_RUN) return;
            nxt = 0;
        end
        if (nxt == m_cur) return;
        old = m_cur;
        // the kernel is never queued and stays marked running
        if (m_state[old] == ST_RUN && old != 0)
        begin
            m_state[old] = ST_READY;
            queue_insert(old);
        end
        if (m_state[nxt] == ST_READY) queue_remove(nxt);
        m_state[nxt] = ST_RUN;
        m_slice_left = m_slice_len;
        m_cur = nxt;
    endtask

    task automatic release_slot(int s);
        if (m_state[s] == ST_READY) queue_remove(s);
        m_state[s] = ST_FREE;
        m_pid[s] = '0;
        m_prio[s] = '0;
        if (s == m_cur) pick_next_task();
    endtask

    task automatic predict_command(logic [2:0] c, logic [7:0] pr, logic [15:0] tp);
        sched_result_t r;
        int prev_slot;
        int found;
        r = '0;
        prev_slot = m_cur;
        found = NIL;
        case (c)
            CMD_CREATE:
            begin
                for (int s = 1; s < NSLOT; s++)
                    if (found == NIL && m_state[s] == ST_FREE) found = s;
                if (found == NIL) r.status = RES_NO_SLOT;
                else
                begin
                    m_pid[found] = m_pid_ctr;
                    r.new_pid = m_pid_ctr;
                    m_pid_ctr = m_pid_ctr + 1'b1;
                    if (m_pid_ctr == 0) m_pid_ctr = PID_FIRST;
                    m_state[found] = ST_READY;
                    m_prio[found] = pr;
                    queue_insert(found);
                end
            end
            CMD_KILL:
            begin
                if (tp == 0) r.status = RES_KERNEL;
                else
                begin
                    for (int s = 0; s < NSLOT; s++)
                        if (found == NIL && m_state[s] != ST_FREE && m_pid[s] == tp) found = s;
                    if (found == NIL) r.status = RES_NOT_FOUND;
                    else release_slot(found);
                end
            end
            CMD_YIELD:
            begin
                if (m_enable)
                begin
                    m_slice_left = m_slice_len;
                    pick_next_task();
                end
            end
            CMD_TICK:
            begin
                if (m_enable)
                begin
                    if (m_slice_left > 0) m_slice_left--;
                    if (m_slice_left == 0) pick_next_task();
                end
            end
            CMD_KILL_SELF:
            begin
                if (m_cur == 0) r.status = RES_KERNEL;
                else if (m_state[m_cur] == ST_FREE) r.status = RES_NOT_FOUND;
                else release_slot(m_cur);
            end
            default: ;
        endcase
        r.running_pid = m_pid[m_cur];
        r.running_slot = m_cur[3:0];
        r.switched = (m_cur != prev_slot);
        pending_results.push_back(r);
    endtask

    // ---------------- result checker ----------------
    always @(posedge clk)
    begin
        sched_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction");
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status exp %0d got %0d", exp_r.status, status);
                    error_count++;
                end
                if (new_pid !== exp_r.new_pid)
                begin
                    $error("new_pid exp %0d got %0d", exp_r.new_pid, new_pid);
                    error_count++;
                end
                if (running_pid !== exp_r.running_pid)
                begin
                    $error("running_pid exp %0d got %0d", exp_r.running_pid, running_pid);
                    error_count++;
                end
                if (running_slot !== exp_r.running_slot)
                begin
                    $error("running_slot exp %0d got %0d", exp_r.running_slot, running_slot);
                    error_count++;
                end
                if (switched !== exp_r.switched)
                begin
                    $error("switched exp %0d got %0d", exp_r.switched, switched);
                    error_count++;
                end
            end
        end
    end

    // ---------------- drivers ----------------
    task automatic idle_burst();
        if (idle_enable && $urandom_range(3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge clk);
        end
    endtask

    // one command transaction; start held until accepted, dropped by the next idle
    task automatic send_command(logic [2:0] c, logic [7:0] pr, logic [15:0] tp);
        idle_burst();
        start <= 1'b1;
        cmd <= c;
        task_priority <= pr;
        target_pid <= tp;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_command(c, pr, tp);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // register write; only called with nothing in flight
    task automatic write_register(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_ENABLE) m_enable = data[0];
        else if (addr == ADDR_SLICE) m_slice_len = data[15:0];
        @(posedge clk);
    endtask

    task automatic configure(bit en, logic [15:0] slice);
        drain_results();
        write_register(ADDR_ENABLE, {31'd0, en});
        write_register(ADDR_SLICE, {16'd0, slice});
    endtask

    function automatic logic [15:0] live_pid();
        int s;
        s = $urandom_range(NSLOT - 1);
        return m_pid[s];
    endfunction

    // ---------------- tests ----------------
    task automatic test_disabled_basics();
        // scheduling off: create, kills and refusals, kernel stays current
        send_command(CMD_YIELD, 8'd0, 16'd0);
        send_command(CMD_TICK, 8'd0, 16'd0);
        send_command(CMD_CREATE, 8'd255, 16'd0);
        send_command(CMD_CREATE, 8'd0, 16'd0);
        send_command(CMD_KILL, 8'd0, 16'd0);
        send_command(CMD_KILL_SELF, 8'd0, 16'd0);
        send_command(CMD_KILL, 8'd0, 16'hFFFF);
        send_command(CMD_KILL, 8'd0, 16'd1);
        send_command(3'd5, 8'hFF, 16'hFFFF);
        send_command(3'd7, 8'd0, 16'd0);
    endtask

    task automatic test_full_table();
        // fill every free slot; the creates beyond the free slots are refused
        for (int i = 0; i < NSLOT; i++)
            send_command(CMD_CREATE, 8'($urandom_range(3)), 16'd0);
    endtask

    task automatic test_switching();
        // enabled with slice one: ticks, then a yield and a kill of the running task
        configure(1'b1, 16'd1);
        repeat (4) send_command(CMD_TICK, 8'd0, 16'd0);
        send_command(CMD_YIELD, 8'd0, 16'd0);
        send_command(CMD_KILL_SELF, 8'd0, 16'd0);
        // slice zero: every tick reschedules
        configure(1'b1, 16'd0);
        repeat (3) send_command(CMD_TICK, 8'd0, 16'd0);
        // running task killed while disabled leaves the current slot freed
        configure(1'b0, 16'hFFFF);
        send_command(CMD_KILL_SELF, 8'd0, 16'd0);
        send_command(CMD_KILL_SELF, 8'd0, 16'd0);
        configure(1'b1, 16'hFFFF);
        send_command(CMD_YIELD, 8'd0, 16'd0);
    endtask

    task automatic test_random(int n);
        int r;
        logic [2:0] c;
        logic [15:0] tp;
        for (int i = 0; i < n; i++)
        begin
            if (i % 300 == 299)
                configure($urandom_range(3) != 0, ($urandom_range(3) == 0)
                          ? 16'($urandom) : 16'($urandom_range(4)));
            r = $urandom_range(99);
            if (r < 25) c = CMD_CREATE;
            else if (r < 40) c = CMD_KILL;
            else if (r < 55) c = CMD_YIELD;
            else if (r < 85) c = CMD_TICK;
            else if (r < 97) c = CMD_KILL_SELF;
            else c = 3'($urandom_range(7, 5));
            tp = ($urandom_range(4) == 0) ? 16'($urandom) : live_pid();
            send_command(c, 8'($urandom), tp);
        end
    endtask

    initial
    begin
        model_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_disabled_basics();
        test_full_table();
        test_switching();
        test_random(1200);
        idle_enable = 1'b0;
        test_random(300);
        drain_results();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // about 1550 commands plus drains stay well under 1 ms
    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: sim.f
sv/pts_pkg.sv
sv/pts_table.sv
sv/pts_ctrl.sv
sv/priority_time_slice_scheduler.sv
sim/testbench.sv
